### rtl/nsfa_pkg.sv
// Shared types and constants of the nearest-neighbor scale fit address generator.
// Holds register indexes, field widths and the context structs carried down the pipeline.
// No dependencies.
package nsfa_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SRC_WIDTH    = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_AREA_LEFT    = 3'd2;
  localparam logic [2:0] REG_AREA_TOP     = 3'd3;
  localparam logic [2:0] REG_AREA_WIDTH   = 3'd4;
  localparam logic [2:0] REG_AREA_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_ZOOM_PERCENT = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Parameter defaults
  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 600;
  localparam int MAX_SRC_DIM_DEF   = 4096;

  // Fixed limits
  localparam logic [11:0] AREA_MAX  = 12'd2048;
  localparam logic [8:0]  ZOOM_MIN  = 9'd25;
  localparam logic [8:0]  ZOOM_MAX  = 9'd400;
  localparam logic [8:0]  ZOOM_RST  = 9'd100;

  // Reciprocal of one hundred percent: x / 100 == (x * PCT_RECIP) >> PCT_SHIFT
  // for every zoomed size below 2**21
  localparam logic [21:0] PCT_RECIP = 22'd2684355;
  localparam int          PCT_SHIFT = 28;

  // Clamped configuration plus the destination coordinate of one transaction
  typedef struct packed {
    logic [12:0]        sw;
    logic [12:0]        sh;
    logic [11:0]        aw;
    logic [11:0]        ah;
    logic [8:0]         zm;
    logic signed [11:0] al;
    logic signed [11:0] at;
    logic [12:0]        dx;
    logic [12:0]        dy;
  } ctx_t;

  // What the final stage needs once visibility is known
  typedef struct packed {
    logic        vis;
    logic [11:0] px;
    logic [11:0] py;
    logic [13:0] dw;
    logic [13:0] dh;
    logic [12:0] sw;
  } pix_t;

endpackage

### rtl/nsfa_div_cell.sv
// One cell of the pipelined restoring divider: settles one quotient bit of two lanes.
// Uses no package; widths come from parameters of the divider chain.
module nsfa_div_cell #(
  parameter int NUM_W  = 25,
  parameter int DEN_W  = 13,
  parameter int Q_W    = 25,
  parameter int SIDE_W = 1,
  parameter int BIT    = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_rem_a,
  input  logic [NUM_W-1:0]  in_rem_b,
  input  logic [DEN_W-1:0]  in_den_a,
  input  logic [DEN_W-1:0]  in_den_b,
  input  logic [Q_W-1:0]    in_q_a,
  input  logic [Q_W-1:0]    in_q_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_rem_a,
  output logic [NUM_W-1:0]  out_rem_b,
  output logic [DEN_W-1:0]  out_den_a,
  output logic [DEN_W-1:0]  out_den_b,
  output logic [Q_W-1:0]    out_q_a,
  output logic [Q_W-1:0]    out_q_b,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CW = NUM_W + DEN_W;

  logic [CW-1:0]    trial_a, trial_b, ext_a, ext_b, diff_a, diff_b;
  logic             ge_a, ge_b;
  logic             valid_r;
  logic [NUM_W-1:0] rem_a_r, rem_b_r, rem_a_nxt, rem_b_nxt;
  logic [DEN_W-1:0] den_a_r, den_b_r;
  logic [Q_W-1:0]   q_a_r, q_b_r, q_a_nxt, q_b_nxt;
  logic [SIDE_W-1:0] side_r;

  // Trial subtract of the shifted divisor in both lanes
  always_comb begin
    trial_a   = {{NUM_W{1'b0}}, in_den_a} << BIT;
    trial_b   = {{NUM_W{1'b0}}, in_den_b} << BIT;
    ext_a     = {{DEN_W{1'b0}}, in_rem_a};
    ext_b     = {{DEN_W{1'b0}}, in_rem_b};
    ge_a      = ext_a >= trial_a;
    ge_b      = ext_b >= trial_b;
    diff_a    = ext_a - trial_a;
    diff_b    = ext_b - trial_b;
    rem_a_nxt = ge_a ? diff_a[NUM_W-1:0] : in_rem_a;
    rem_b_nxt = ge_b ? diff_b[NUM_W-1:0] : in_rem_b;
    q_a_nxt      = in_q_a;
    q_b_nxt      = in_q_b;
    q_a_nxt[BIT] = ge_a;
    q_b_nxt[BIT] = ge_b;
  end

  // Hand the partial result to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    rem_a_r <= rem_a_nxt;
    rem_b_r <= rem_b_nxt;
    den_a_r <= in_den_a;
    den_b_r <= in_den_b;
    q_a_r   <= q_a_nxt;
    q_b_r   <= q_b_nxt;
    side_r  <= in_side;
  end

  assign out_valid = valid_r;
  assign out_rem_a = rem_a_r;
  assign out_rem_b = rem_b_r;
  assign out_den_a = den_a_r;
  assign out_den_b = den_b_r;
  assign out_q_a   = q_a_r;
  assign out_q_b   = q_b_r;
  assign out_side  = side_r;

endmodule

### rtl/nsfa_div_pair.sv
// Two-lane pipelined divider built as a chain of nsfa_div_cell, one quotient bit per cell.
// Depends on nsfa_div_cell. Quotient is exact while num < den * 2**Q_W.
module nsfa_div_pair #(
  parameter int NUM_W  = 25,
  parameter int DEN_W  = 13,
  parameter int Q_W    = 25,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num_a,
  input  logic [NUM_W-1:0]  in_num_b,
  input  logic [DEN_W-1:0]  in_den_a,
  input  logic [DEN_W-1:0]  in_den_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_q_a,
  output logic [Q_W-1:0]    out_q_b,
  output logic [SIDE_W-1:0] out_side
);

  logic              v    [0:Q_W];
  logic [NUM_W-1:0]  rem_a[0:Q_W];
  logic [NUM_W-1:0]  rem_b[0:Q_W];
  logic [DEN_W-1:0]  den_a[0:Q_W];
  logic [DEN_W-1:0]  den_b[0:Q_W];
  logic [Q_W-1:0]    q_a  [0:Q_W];
  logic [Q_W-1:0]    q_b  [0:Q_W];
  logic [SIDE_W-1:0] side [0:Q_W];

  // Feed the head of the chain
  assign v[0]     = in_valid;
  assign rem_a[0] = in_num_a;
  assign rem_b[0] = in_num_b;
  assign den_a[0] = in_den_a;
  assign den_b[0] = in_den_b;
  assign q_a[0]   = '0;
  assign q_b[0]   = '0;
  assign side[0]  = in_side;

  // Settle quotient bits from the top down
  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    nsfa_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .Q_W   (Q_W),
      .SIDE_W(SIDE_W),
      .BIT   (Q_W - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v[i]),
      .in_rem_a (rem_a[i]),
      .in_rem_b (rem_b[i]),
      .in_den_a (den_a[i]),
      .in_den_b (den_b[i]),
      .in_q_a   (q_a[i]),
      .in_q_b   (q_b[i]),
      .in_side  (side[i]),
      .out_valid(v[i+1]),
      .out_rem_a(rem_a[i+1]),
      .out_rem_b(rem_b[i+1]),
      .out_den_a(den_a[i+1]),
      .out_den_b(den_b[i+1]),
      .out_q_a  (q_a[i+1]),
      .out_q_b  (q_b[i+1]),
      .out_side (side[i+1])
    );
  end

  assign out_valid = v[Q_W];
  assign out_q_a   = q_a[Q_W];
  assign out_q_b   = q_b[Q_W];
  assign out_side  = side[Q_W];

endmodule

### rtl/nearest_scale_fit_address_gen.sv
// Top level of the nearest-neighbor scale fit address generator.
// Depends on nsfa_pkg and nsfa_div_pair (chains of nsfa_div_cell).
//
// One destination coordinate is taken per clock (start while busy is low; busy
// never rises) and exactly one result follows for each, in order, with out_strobe
// high for one cycle; the receiver cannot stall. The path holds 6 register stages
// plus the two divider chains of 25 and 13 cells, one quotient bit per cell. Each
// transaction carries its own snapshot of the configuration, so a register write
// takes effect on the next accepted coordinate.
module nearest_scale_fit_address_gen #(
  parameter int SCREEN_WIDTH  = nsfa_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = nsfa_pkg::SCREEN_HEIGHT_DEF,
  parameter int MAX_SRC_DIM   = nsfa_pkg::MAX_SRC_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nsfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [12:0]                     in_dest_col,
  input  logic [12:0]                     in_dest_row,
  output logic                            out_strobe,
  output logic                            out_visible,
  output logic [9:0]                      out_screen_col,
  output logic [9:0]                      out_screen_row,
  output logic [19:0]                     out_fb_address,
  output logic [11:0]                     out_src_col,
  output logic [11:0]                     out_src_row,
  output logic [23:0]                     out_src_index,
  output logic [13:0]                     out_drawn_width,
  output logic [13:0]                     out_drawn_height
);

  import nsfa_pkg::*;

  localparam logic [13:0] MAX_SRC = 14'(MAX_SRC_DIM);
  localparam logic signed [16:0] SCR_W = 17'(SCREEN_WIDTH);
  localparam logic signed [16:0] SCR_H = 17'(SCREEN_HEIGHT);
  localparam logic [12:0] SCR_W_U = 13'(SCREEN_WIDTH);

  // Configuration registers
  logic [12:0] src_width_r, src_height_r;
  logic [11:0] area_left_r, area_top_r, area_width_r, area_height_r;
  logic [8:0]  zoom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= 13'd1;
      src_height_r  <= 13'd1;
      area_left_r   <= 12'd0;
      area_top_r    <= 12'd0;
      area_width_r  <= 12'd1;
      area_height_r <= 12'd1;
      zoom_r        <= ZOOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:    src_width_r   <= cfg_data;
        REG_SRC_HEIGHT:   src_height_r  <= cfg_data;
        REG_AREA_LEFT:    area_left_r   <= cfg_data[11:0];
        REG_AREA_TOP:     area_top_r    <= cfg_data[11:0];
        REG_AREA_WIDTH:   area_width_r  <= cfg_data[11:0];
        REG_AREA_HEIGHT:  area_height_r <= cfg_data[11:0];
        REG_ZOOM_PERCENT: zoom_r        <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Clamp the registers and capture one transaction
  ctx_t ctx_nxt;
  logic s1_valid_r;
  ctx_t s1_ctx_r;

  always_comb begin
    ctx_nxt.sw = (src_width_r == 13'd0) ? 13'd1 :
                 ({1'b0, src_width_r} > MAX_SRC) ? MAX_SRC[12:0] : src_width_r;
    ctx_nxt.sh = (src_height_r == 13'd0) ? 13'd1 :
                 ({1'b0, src_height_r} > MAX_SRC) ? MAX_SRC[12:0] : src_height_r;
    ctx_nxt.aw = (area_width_r == 12'd0) ? 12'd1 :
                 (area_width_r > AREA_MAX) ? AREA_MAX : area_width_r;
    ctx_nxt.ah = (area_height_r == 12'd0) ? 12'd1 :
                 (area_height_r > AREA_MAX) ? AREA_MAX : area_height_r;
    ctx_nxt.zm = (zoom_r < ZOOM_MIN) ? ZOOM_MIN :
                 (zoom_r > ZOOM_MAX) ? ZOOM_MAX : zoom_r;
    ctx_nxt.al = $signed(area_left_r);
    ctx_nxt.at = $signed(area_top_r);
    ctx_nxt.dx = in_dest_col;
    ctx_nxt.dy = in_dest_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    s1_ctx_r <= ctx_nxt;
  end

  // Form the cross products for the aspect fit
  logic        s2_valid_r;
  ctx_t        s2_ctx_r;
  logic [24:0] s2_pa_r, s2_pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_ctx_r <= s1_ctx_r;
    s2_pa_r  <= s1_ctx_r.sh * s1_ctx_r.aw;
    s2_pb_r  <= s1_ctx_r.sw * s1_ctx_r.ah;
  end

  // Divide out the fitted height and the alternative fitted width
  logic                d1_valid;
  logic [24:0]         d1_fh, d1_fw;
  logic [$bits(ctx_t)-1:0] d1_side;
  ctx_t                d1_ctx;

  nsfa_div_pair #(
    .NUM_W(25), .DEN_W(13), .Q_W(25), .SIDE_W($bits(ctx_t))
  ) u_div_fit (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s2_valid_r),
    .in_num_a (s2_pa_r),
    .in_num_b (s2_pb_r),
    .in_den_a (s2_ctx_r.sw),
    .in_den_b (s2_ctx_r.sh),
    .in_side  (s2_ctx_r),
    .out_valid(d1_valid),
    .out_q_a  (d1_fh),
    .out_q_b  (d1_fw),
    .out_side (d1_side)
  );

  assign d1_ctx = ctx_t'(d1_side);

  // Pick the fit and apply the zoom
  logic        over_h;
  logic [11:0] fw, fh;
  logic        s3_valid_r;
  ctx_t        s3_ctx_r;
  logic [20:0] s3_zw_r, s3_zh_r;

  always_comb begin
    over_h = d1_fh > {13'd0, d1_ctx.ah};
    fw     = over_h ? d1_fw[11:0] : d1_ctx.aw;
    fh     = over_h ? d1_ctx.ah : d1_fh[11:0];
    if (fw == 12'd0) fw = 12'd1;
    if (fh == 12'd0) fh = 12'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= d1_valid;
    end
    s3_ctx_r <= d1_ctx;
    s3_zw_r  <= fw * d1_ctx.zm;
    s3_zh_r  <= fh * d1_ctx.zm;
  end

  // Divide by one hundred percent through a reciprocal multiply
  logic [42:0] zprod_w, zprod_h;
  logic        d2_valid_r;
  ctx_t        d2_ctx_r;
  logic [13:0] d2_dw_r, d2_dh_r;
  logic        d2_valid;
  logic [13:0] d2_dw, d2_dh;
  ctx_t        d2_ctx;

  always_comb begin
    zprod_w = s3_zw_r * PCT_RECIP;
    zprod_h = s3_zh_r * PCT_RECIP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_valid_r <= 1'b0;
    end else begin
      d2_valid_r <= s3_valid_r;
    end
    d2_ctx_r <= s3_ctx_r;
    d2_dw_r  <= zprod_w[PCT_SHIFT +: 14];
    d2_dh_r  <= zprod_h[PCT_SHIFT +: 14];
  end

  assign d2_valid = d2_valid_r;
  assign d2_dw    = d2_dw_r;
  assign d2_dh    = d2_dh_r;
  assign d2_ctx   = d2_ctx_r;

  // Center, place and clip the pixel
  logic [13:0]        dw, dh;
  logic signed [16:0] diff_w, diff_h, half_w, half_h, px, py;
  logic signed [16:0] left, top, right, bottom;
  logic               vis;
  pix_t               pix;
  logic               s4_valid_r;
  pix_t               s4_pix_r;
  logic [25:0]        s4_nx_r, s4_ny_r;

  always_comb begin
    dw = (d2_dw[13:0] == 14'd0) ? 14'd1 : d2_dw[13:0];
    dh = (d2_dh[13:0] == 14'd0) ? 14'd1 : d2_dh[13:0];
    diff_w = $signed({5'd0, d2_ctx.aw}) - $signed({3'd0, dw});
    diff_h = $signed({5'd0, d2_ctx.ah}) - $signed({3'd0, dh});
    // Halve with truncation toward zero
    half_w = (diff_w + $signed({16'd0, diff_w[16]})) >>> 1;
    half_h = (diff_h + $signed({16'd0, diff_h[16]})) >>> 1;
    left   = 17'(d2_ctx.al);
    top    = 17'(d2_ctx.at);
    right  = left + $signed({5'd0, d2_ctx.aw});
    bottom = top + $signed({5'd0, d2_ctx.ah});
    px = left + half_w + $signed({4'd0, d2_ctx.dx});
    py = top + half_h + $signed({4'd0, d2_ctx.dy});
    vis = ({1'b0, d2_ctx.dx} < dw) && ({1'b0, d2_ctx.dy} < dh)
       && (px >= left) && (px < right) && (px >= 17'sd0) && (px < SCR_W)
       && (py >= top) && (py < bottom) && (py >= 17'sd0) && (py < SCR_H);
    pix.vis = vis;
    pix.px  = px[11:0];
    pix.py  = py[11:0];
    pix.dw  = dw;
    pix.dh  = dh;
    pix.sw  = d2_ctx.sw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= d2_valid;
    end
    s4_pix_r <= pix;
    s4_nx_r  <= d2_ctx.dx * d2_ctx.sw;
    s4_ny_r  <= d2_ctx.dy * d2_ctx.sh;
  end

  // Divide out the nearest source coordinate
  logic                d3_valid;
  logic [12:0]         d3_sx, d3_sy;
  logic [$bits(pix_t)-1:0] d3_side;
  pix_t                d3_pix;

  nsfa_div_pair #(
    .NUM_W(26), .DEN_W(14), .Q_W(13), .SIDE_W($bits(pix_t))
  ) u_div_src (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s4_valid_r),
    .in_num_a (s4_nx_r),
    .in_num_b (s4_ny_r),
    .in_den_a (s4_pix_r.dw),
    .in_den_b (s4_pix_r.dh),
    .in_side  (s4_pix_r),
    .out_valid(d3_valid),
    .out_q_a  (d3_sx),
    .out_q_b  (d3_sy),
    .out_side (d3_side)
  );

  assign d3_pix = pix_t'(d3_side);

  // Form the addresses and register the result
  logic [24:0] fb_full;
  logic [25:0] si_full;
  logic        out_strobe_r, vis_r;
  logic [9:0]  scol_r, srow_r;
  logic [19:0] fb_r;
  logic [11:0] sc_r, sr_r;
  logic [23:0] si_r;
  logic [13:0] dw_r, dh_r;

  always_comb begin
    fb_full = d3_pix.py * SCR_W_U + {13'd0, d3_pix.px};
    si_full = d3_sy * d3_pix.sw + {13'd0, d3_sx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= d3_valid;
    end
    vis_r  <= d3_pix.vis;
    scol_r <= d3_pix.vis ? d3_pix.px[9:0] : 10'd0;
    srow_r <= d3_pix.vis ? d3_pix.py[9:0] : 10'd0;
    fb_r   <= d3_pix.vis ? fb_full[19:0] : 20'd0;
    sc_r   <= d3_pix.vis ? d3_sx[11:0] : 12'd0;
    sr_r   <= d3_pix.vis ? d3_sy[11:0] : 12'd0;
    si_r   <= d3_pix.vis ? si_full[23:0] : 24'd0;
    dw_r   <= d3_pix.dw;
    dh_r   <= d3_pix.dh;
  end

  assign out_strobe       = out_strobe_r;
  assign out_visible      = vis_r;
  assign out_screen_col   = scol_r;
  assign out_screen_row   = srow_r;
  assign out_fb_address   = fb_r;
  assign out_src_col      = sc_r;
  assign out_src_row      = sr_r;
  assign out_src_index    = si_r;
  assign out_drawn_width  = dw_r;
  assign out_drawn_height = dh_r;

endmodule
